[hw/rtl/ttbl_pkg.sv]
// Shared types and constants of the text token boundary lexer.
// Used by the front end, the result queue, the back end and the top level.
// No dependencies.
package ttbl_pkg;

  localparam logic [2:0] KIND_NEWLINE   = 3'd0;
  localparam logic [2:0] KIND_PARAGRAPH = 3'd1;
  localparam logic [2:0] KIND_INDENT    = 3'd2;
  localparam logic [2:0] KIND_WORD      = 3'd3;
  localparam logic [2:0] KIND_SYMBOL    = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd5;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_BREAK = 2'd1;
  localparam logic [1:0] MODE_BLANK = 2'd2;
  localparam logic [1:0] MODE_WORD  = 2'd3;

  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_DEL      = 8'h7F;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] token_byte;
    logic       token_start;
    logic       token_end;
    logic       last_of_run;
  } out_item_t;

  // One queue entry holds all results of one request: r0, plus r1 when two is set.
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hw/rtl/text_token_boundary_lexer_core.sv]
// Text token boundary lexer, top level: front end, result queue, back end.
// Results of an accepted byte are written into the registered queue and shown from its head.
// Throughput: one byte per cycle while the queue has room; results leave at one
// per cycle while out_pop is asserted, through the single output port.
// Reset: synchronous, active low; clears the run state and empties the queue.
module text_token_boundary_lexer_core
  import ttbl_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      in_push,
  output logic      in_full,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  logic          accept;
  logic          wr_en;
  entry_t        wr_entry;
  logic          rd_en;
  entry_t        head;
  queue_status_t status;

  assign in_full = status.full;
  assign accept = in_push && !status.full;

  ttbl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_item),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  ttbl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_data (head),
    .status  (status)
  );

  ttbl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (status),
    .rd_en     (rd_en),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("results pending right after reset");

  a_single_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.token_kind != KIND_WORD |->
      out_item.token_start && out_item.token_end)
    else $error("single-result token without start and end marks");

endmodule

[hw/rtl/ttbl_front.sv]
// Front end of the lexer: holds the run state, classifies each accepted byte
// and forms the results it causes (none, one or two) as one queue entry.
// Depends on ttbl_pkg.
module ttbl_front
  import ttbl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  in_item_t      in_item,
  output logic          wr_en,
  output entry_t        wr_entry
);

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } close_tok_t;

  logic [1:0] mode_r, mode_nxt;
  logic       cr_r, cr_nxt;
  logic [1:0] nlt_r, nlt_nxt;
  logic [1:0] blt_r, blt_nxt;
  logic       tab_r, tab_nxt;
  logic [7:0] hb_r, hb_nxt;
  logic       hf_r, hf_nxt;

  function automatic close_tok_t close_tok(input logic [1:0] mode, input logic [1:0] nlt,
                                           input logic [1:0] blt, input logic tab,
                                           input logic [7:0] hb, input logic hf);
    close_tok_t t;
    t = '0;
    unique case (mode)
      MODE_BREAK: begin
        t.vld = 1'b1;
        t.item.token_kind = (nlt >= 2'd2) ? KIND_PARAGRAPH : KIND_NEWLINE;
        t.item.token_start = 1'b1;
        t.item.token_end = 1'b1;
      end
      MODE_BLANK: begin
        t.vld = tab || (blt >= 2'd2);
        t.item.token_kind = KIND_INDENT;
        t.item.token_start = 1'b1;
        t.item.token_end = 1'b1;
      end
      MODE_WORD: begin
        t.vld = 1'b1;
        t.item.token_kind = KIND_WORD;
        t.item.token_byte = hb;
        t.item.token_start = hf;
        t.item.token_end = 1'b1;
      end
      default: begin
        t.vld = 1'b0;
      end
    endcase
    return t;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       is_nl;
    logic       is_bl;
    logic       is_wd;
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
    out_item_t  x;
    close_tok_t ct;
    b = in_item.text_byte;
    is_nl = (b == CHAR_CR) || (b == CHAR_LF);
    is_bl = (b == CHAR_SPACE) || (b == CHAR_TAB);
    is_wd = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h30 && b <= 8'h39);
    cnt = 2'd0;
    r0 = '0;
    r1 = '0;
    x = '0;
    ct = '0;
    mode_nxt = mode_r;
    cr_nxt = cr_r;
    nlt_nxt = nlt_r;
    blt_nxt = blt_r;
    tab_nxt = tab_r;
    hb_nxt = hb_r;
    hf_nxt = hf_r;

    if (mode_r == MODE_BREAK && is_nl) begin
      if (b == CHAR_LF && cr_r) begin
        cr_nxt = 1'b0;
      end else begin
        if (nlt_r < 2'd2) begin
          nlt_nxt = nlt_r + 2'd1;
        end
        cr_nxt = (b == CHAR_CR);
      end
    end else if (mode_r == MODE_BREAK && is_bl) begin
      cr_nxt = 1'b0;
    end else if (mode_r == MODE_BLANK && is_bl) begin
      if (blt_r < 2'd2) begin
        blt_nxt = blt_r + 2'd1;
      end
      if (b == CHAR_TAB) begin
        tab_nxt = 1'b1;
      end
    end else if (mode_r == MODE_WORD && is_wd) begin
      x = '0;
      x.token_kind = KIND_WORD;
      x.token_byte = hb_r;
      x.token_start = hf_r;
      r0 = x;
      cnt = 2'd1;
      hb_nxt = b;
      hf_nxt = 1'b0;
    end else begin
      ct = close_tok(mode_r, nlt_r, blt_r, tab_r, hb_r, hf_r);
      if (ct.vld) begin
        r0 = ct.item;
        cnt = 2'd1;
      end
      mode_nxt = MODE_IDLE;
      cr_nxt = 1'b0;
      nlt_nxt = 2'd0;
      blt_nxt = 2'd0;
      tab_nxt = 1'b0;
      hb_nxt = 8'd0;
      hf_nxt = 1'b0;
      if (is_nl) begin
        mode_nxt = MODE_BREAK;
        nlt_nxt = 2'd1;
        cr_nxt = (b == CHAR_CR);
      end else if (is_bl) begin
        mode_nxt = MODE_BLANK;
        blt_nxt = 2'd1;
        tab_nxt = (b == CHAR_TAB);
      end else if (is_wd) begin
        mode_nxt = MODE_WORD;
        hb_nxt = b;
        hf_nxt = 1'b1;
      end else begin
        x = '0;
        x.token_start = 1'b1;
        x.token_end = 1'b1;
        if (b >= CHAR_SPACE && b < CHAR_DEL) begin
          x.token_kind = KIND_SYMBOL;
          x.token_byte = b;
        end else begin
          x.token_kind = KIND_UNKNOWN;
        end
        if (cnt == 2'd0) begin
          r0 = x;
        end else begin
          r1 = x;
        end
        cnt = cnt + 2'd1;
      end
    end

    if (in_item.end_of_text) begin
      ct = close_tok(mode_nxt, nlt_nxt, blt_nxt, tab_nxt, hb_nxt, hf_nxt);
      if (ct.vld && cnt < 2'd2) begin
        if (cnt == 2'd0) begin
          r0 = ct.item;
        end else begin
          r1 = ct.item;
        end
        cnt = cnt + 2'd1;
      end
      mode_nxt = MODE_IDLE;
      cr_nxt = 1'b0;
      nlt_nxt = 2'd0;
      blt_nxt = 2'd0;
      tab_nxt = 1'b0;
      hb_nxt = 8'd0;
      hf_nxt = 1'b0;
    end

    if (cnt == 2'd1) begin
      r0.last_of_run = 1'b1;
    end else if (cnt == 2'd2) begin
      r1.last_of_run = 1'b1;
    end

    wr_en = accept && (cnt != 2'd0);
    wr_entry.two = (cnt == 2'd2);
    wr_entry.r0 = r0;
    wr_entry.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cr_r <= 1'b0;
      nlt_r <= 2'd0;
      blt_r <= 2'd0;
      tab_r <= 1'b0;
      hb_r <= 8'd0;
      hf_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cr_r <= cr_nxt;
      nlt_r <= nlt_nxt;
      blt_r <= blt_nxt;
      tab_r <= tab_nxt;
      hb_r <= hb_nxt;
      hf_r <= hf_nxt;
    end
  end

  // A final byte always leaves the lexer idle.
  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.end_of_text |=> mode_r == MODE_IDLE)
    else $error("lexer not idle after final byte");

  // The first-byte mark only lives inside a word run.
  a_first_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    hf_r |-> mode_r == MODE_WORD)
    else $error("held first mark outside word run");

endmodule

[hw/rtl/ttbl_fifo.sv]
// Short register queue of result entries between front and back end.
// Depends on ttbl_pkg.
module ttbl_fifo
  import ttbl_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  entry_t        wr_data,
  input  logic          rd_en,
  output entry_t        rd_data,
  output queue_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_wr;
  logic               do_rd;

  assign status.full = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[hw/rtl/ttbl_back.sv]
// Back end of the lexer: drains queue entries and hands out their results
// one per cycle on the result channel while out_pop is asserted.
// Depends on ttbl_pkg.
module ttbl_back
  import ttbl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  entry_t        head,
  input  queue_status_t status,
  output logic          rd_en,
  output out_item_t     out_item,
  output logic          out_empty,
  input  logic          out_pop
);

  logic sub_r, sub_nxt;
  logic take;

  assign out_empty = status.empty;
  assign out_item = sub_r ? head.r1 : head.r0;
  assign take = out_pop && !status.empty;
  assign rd_en = take && (sub_r == head.two);

  always_comb begin
    sub_nxt = sub_r;
    if (take) begin
      sub_nxt = !rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

  // The second result is only ever selected within a two-result entry.
  a_sub_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> !status.empty && head.two)
    else $error("second result selected without such an entry");

endmodule
